// File: rtl/lqrsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lqrsf_pkg;

   // Problem size
   localparam int STATE_COMPONENTS = 12;
   localparam int COMMAND_OUTPUTS  = 4;
   localparam int GAIN_DEPTH       = STATE_COMPONENTS * COMMAND_OUTPUTS;
   localparam int COL_W            = $clog2(STATE_COMPONENTS);
   localparam int ROW_W            = $clog2(COMMAND_OUTPUTS);

   // Number formats
   localparam int Q_W    = 32;
   localparam int ACC_W  = 48;
   localparam int PROD_W = 2 * Q_W;
   localparam int FRAC_W = 16;

   // Yaw wrap constants, Q16.16
   localparam int YAW_COMPONENT = 8;
   localparam int PI_Q16        = 205887;
   localparam int TWO_PI_Q16    = 411775;

   // Stream layout
   localparam int REQ_TDATA_W = 264;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 136;

   // Result queue
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Configuration registers
   localparam int CSR_ADDR_W         = 4;
   localparam int CSR_DATA_W         = 32;
   localparam int DELAY_LIMIT_W      = 31;
   localparam int STALE_LIMIT_W      = 16;
   localparam int THRUST_CEIL_W      = 31;
   localparam int DELAY_LIMIT_RESET  = 200;
   localparam int STALE_LIMIT_RESET  = 100;
   localparam int THRUST_CEIL_RESET  = 524288;

   typedef enum logic [1:0] {
      CSR_DELAY_LIMIT = 2'd0,
      CSR_STALE_LIMIT = 2'd1,
      CSR_THRUST_CEIL = 2'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      ACT_LOAD_GAIN  = 2'd0,
      ACT_SET_STAMP  = 2'd1,
      ACT_BEGIN_STEP = 2'd2,
      ACT_COMPONENT  = 2'd3
   } action_type;

   // Single gain word write into the column-organized store
   typedef struct packed {
      logic             en;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [Q_W-1:0]   data;
   } gain_wr_type;

   // Gain table after reset, Q16.16
   function automatic logic [Q_W-1:0] default_gain(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      logic [Q_W-1:0] g;
      g = '0;
      case ({row, col})
         {2'd0, 4'd2}:  g = Q_W'(286563);
         {2'd0, 4'd5}:  g = Q_W'(177327);
         {2'd1, 4'd1}:  g = Q_W'(-19117);
         {2'd1, 4'd4}:  g = Q_W'(-14562);
         {2'd1, 4'd6}:  g = Q_W'(44342);
         {2'd1, 4'd9}:  g = Q_W'(6914);
         {2'd2, 4'd0}:  g = Q_W'(18809);
         {2'd2, 4'd3}:  g = Q_W'(14326);
         {2'd2, 4'd7}:  g = Q_W'(43601);
         {2'd2, 4'd10}: g = Q_W'(6796);
         {2'd3, 4'd8}:  g = Q_W'(2438);
         {2'd3, 4'd11}: g = Q_W'(7786);
         default:       g = '0;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

// File: rtl/lqrsf_gain_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module lqrsf_gain_mem import lqrsf_pkg::*; (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire gain_wr_type                        wr,
   input  wire logic                               rd_en,
   input  wire logic [COL_W-1:0]                   rd_col,
   output logic      [COMMAND_OUTPUTS-1:0][Q_W-1:0] rd_gain
);

   // One word per state component, holding the gains of all command rows
   logic [COMMAND_OUTPUTS-1:0][Q_W-1:0] mem [STATE_COMPONENTS];
   logic [COMMAND_OUTPUTS-1:0]          vld_ff [STATE_COMPONENTS];

   logic [COMMAND_OUTPUTS-1:0][Q_W-1:0] rd_q_ff;
   logic [COMMAND_OUTPUTS-1:0]          rd_vld_ff;
   logic [COL_W-1:0]                    rd_col_ff;

   // Write one row lane of a column word
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.col][wr.row] <= wr.data;
      end
   end

   // Track lanes written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < STATE_COMPONENTS; c++) begin
            vld_ff[c] <= '0;
         end
      end else if (wr.en) begin
         vld_ff[wr.col][wr.row] <= 1'b1;
      end
   end

   // Registered column read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff   <= mem[rd_col];
         rd_vld_ff <= vld_ff[rd_col];
         rd_col_ff <= rd_col;
      end
   end

   // Unwritten lanes read as the reset table
   always_comb begin
      for (int r = 0; r < COMMAND_OUTPUTS; r++) begin
         rd_gain[r] = rd_vld_ff[r] ? rd_q_ff[r] : default_gain(ROW_W'(r), rd_col_ff);
      end
   end

endmodule

`default_nettype wire

// File: rtl/lqr_state_feedback_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// LQR state-feedback controller: u = u_ff - K*(x - x_ref) in Q16.16 with a 4x12 gain
// store. The block takes one request transaction per clock cycle of any kind; each error
// component reads one gain column from the gain memory and runs four multiply-accumulate
// lanes, one component per transaction. A command passes stages 0 to 2, the accumulators
// and stage 4 to the response side, where up to eight commands queue; the request side
// stalls only while eight commands are in flight or waiting. Configuration registers sit
// at byte addresses 0 (delay limit), 4 (stale count limit) and 8 (thrust ceiling); the
// user must write them only while the block is idle, which the block does not enforce.

module lqr_state_feedback_controller import lqrsf_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // tdata from bit 0: index[6], gain_value[32], measured_value[32], reference_value[32],
   // ff_thrust[32], ff_roll[32], ff_pitch[32], ff_yaw[32], stamp[32], disable_req[1], pad
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // tuser: action[2]
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   input  wire logic                   req_tlast,
   // Response stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // tdata from bit 0: thrust[32], torque_x[32], torque_y[32], torque_z[32], fallback[1], pad
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // Configuration port
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   typedef struct packed {
      logic step;
      logic acc_en;
      logic emit;
      logic dis;
      logic fb;
   } stage_ctl_type;

   typedef struct packed {
      logic                  fallback;
      logic signed [Q_W-1:0] torque_z;
      logic signed [Q_W-1:0] torque_y;
      logic signed [Q_W-1:0] torque_x;
      logic signed [Q_W-1:0] thrust;
   } rsp_item_type;

   typedef logic signed [COMMAND_OUTPUTS-1:0][Q_W-1:0] q_vec_type;

   // ---------------------------------------------------------------------------------
   // Request fields
   // ---------------------------------------------------------------------------------
   action_type            in_action;
   logic [5:0]            in_index;
   logic signed [Q_W-1:0] in_gain;
   logic signed [Q_W-1:0] in_meas;
   logic signed [Q_W-1:0] in_ref;
   q_vec_type             in_ffwd;
   logic [Q_W-1:0]        in_stamp;
   logic                  in_dis;
   logic                  req_acc;

   assign in_action = action_type'(req_tuser);
   assign in_index  = req_tdata[5:0];
   assign in_gain   = req_tdata[37:6];
   assign in_meas   = req_tdata[69:38];
   assign in_ref    = req_tdata[101:70];
   assign in_ffwd   = req_tdata[229:102];
   assign in_stamp  = req_tdata[261:230];
   assign in_dis    = req_tdata[262];
   assign req_acc   = req_tvalid && req_tready;

   // ---------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------
   logic [DELAY_LIMIT_W-1:0] delay_limit_ff;
   logic [STALE_LIMIT_W-1:0] stale_limit_ff;
   logic [THRUST_CEIL_W-1:0] thrust_ceil_ff;
   csr_reg_type              csr_sel;
   logic                     csr_wr;

   assign csr_sel    = csr_reg_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Write on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_limit_ff <= DELAY_LIMIT_W'(DELAY_LIMIT_RESET);
         stale_limit_ff <= STALE_LIMIT_W'(STALE_LIMIT_RESET);
         thrust_ceil_ff <= THRUST_CEIL_W'(THRUST_CEIL_RESET);
      end else if (csr_wr) begin
         unique case (csr_sel)
            CSR_DELAY_LIMIT: delay_limit_ff <= csr_pwdata[DELAY_LIMIT_W-1:0];
            CSR_STALE_LIMIT: stale_limit_ff <= csr_pwdata[STALE_LIMIT_W-1:0];
            CSR_THRUST_CEIL: thrust_ceil_ff <= csr_pwdata[THRUST_CEIL_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (csr_sel)
         CSR_DELAY_LIMIT: csr_prdata = CSR_DATA_W'(delay_limit_ff);
         CSR_STALE_LIMIT: csr_prdata = CSR_DATA_W'(stale_limit_ff);
         CSR_THRUST_CEIL: csr_prdata = CSR_DATA_W'(thrust_ceil_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Gain memory access
   // ---------------------------------------------------------------------------------
   gain_wr_type                         gain_wr;
   logic [5:0]                          wr_col_full;
   logic                                rd_en;
   logic                                comp_hit;
   logic [COMMAND_OUTPUTS-1:0][Q_W-1:0] rd_gain;

   // Split the flat gain index into row and column
   always_comb begin
      gain_wr.row = '0;
      wr_col_full = in_index;
      for (int r = COMMAND_OUTPUTS - 1; r > 0; r--) begin
         if (in_index >= 6'(r * STATE_COMPONENTS) && gain_wr.row == '0) begin
            gain_wr.row = ROW_W'(r);
            wr_col_full = in_index - 6'(r * STATE_COMPONENTS);
         end
      end
      gain_wr.col  = wr_col_full[COL_W-1:0];
      gain_wr.data = in_gain;
      gain_wr.en   = req_acc && in_action == ACT_LOAD_GAIN && in_index < 6'(GAIN_DEPTH);
   end

   assign comp_hit = in_index < 6'(STATE_COMPONENTS);
   assign rd_en    = req_acc && in_action == ACT_COMPONENT && comp_hit;

   lqrsf_gain_mem u_gain_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (gain_wr),
      .rd_en   (rd_en),
      .rd_col  (in_index[COL_W-1:0]),
      .rd_gain (rd_gain)
   );

   // ---------------------------------------------------------------------------------
   // Gain stamp and stale-gain watchdog
   // ---------------------------------------------------------------------------------
   logic [Q_W-1:0] gain_stamp_ff;
   logic [Q_W-1:0] stale_cnt_ff;
   logic           disable_ff;
   logic           fallback_ff;
   logic [Q_W-1:0] gap;
   logic [Q_W-1:0] gap_mag;
   logic           gap_over;
   logic [Q_W-1:0] stale_cnt_inc;

   always_comb begin
      gap           = in_stamp - gain_stamp_ff;
      gap_mag       = gap[Q_W-1] ? (~gap + Q_W'(1)) : gap;
      if (in_dis) begin
         gap_mag = '0;
      end
      gap_over      = gap_mag > Q_W'(delay_limit_ff);
      stale_cnt_inc = (stale_cnt_ff == '1) ? stale_cnt_ff : stale_cnt_ff + Q_W'(1);
   end

   // Update on stamp and step transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_stamp_ff <= '0;
         stale_cnt_ff  <= '0;
         disable_ff    <= 1'b0;
         fallback_ff   <= 1'b0;
      end else if (req_acc) begin
         case (in_action)
            ACT_SET_STAMP: gain_stamp_ff <= in_stamp;
            ACT_BEGIN_STEP: begin
               disable_ff <= in_dis;
               if (gap_over) begin
                  stale_cnt_ff <= stale_cnt_inc;
                  if (stale_cnt_inc > Q_W'(stale_limit_ff)) begin
                     fallback_ff <= 1'b1;
                  end
               end else begin
                  stale_cnt_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 0: error difference, gain column read in flight
   // ---------------------------------------------------------------------------------
   stage_ctl_type         p0_ctl_ff;
   logic                  p0_yaw_ff;
   logic signed [Q_W:0]   p0_diff_ff;
   q_vec_type             p0_ffwd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_ctl_ff <= '0;
      end else begin
         p0_ctl_ff.step   <= req_acc && in_action == ACT_BEGIN_STEP;
         p0_ctl_ff.acc_en <= rd_en;
         p0_ctl_ff.emit   <= req_acc && in_action == ACT_COMPONENT && req_tlast;
         p0_ctl_ff.dis    <= disable_ff;
         p0_ctl_ff.fb     <= fallback_ff;
      end
   end

   always_ff @(posedge clock) begin
      p0_yaw_ff  <= in_index == 6'(YAW_COMPONENT);
      p0_diff_ff <= {in_meas[Q_W-1], in_meas} - {in_ref[Q_W-1], in_ref};
      p0_ffwd_ff <= in_ffwd;
   end

   // ---------------------------------------------------------------------------------
   // Stage 1: yaw wrap and saturation, gain column captured
   // ---------------------------------------------------------------------------------
   stage_ctl_type           p1_ctl_ff;
   logic signed [Q_W-1:0]   p1_err_ff;
   q_vec_type               p1_gain_ff;
   q_vec_type               p1_ffwd_ff;
   logic signed [Q_W+1:0]   err_wrap;
   logic signed [Q_W-1:0]   err_sat;

   always_comb begin
      err_wrap = {p0_diff_ff[Q_W], p0_diff_ff};
      if (p0_yaw_ff) begin
         if (p0_diff_ff > (Q_W+1)'(PI_Q16)) begin
            err_wrap = err_wrap - (Q_W+2)'(TWO_PI_Q16);
         end else if (p0_diff_ff < -(Q_W+1)'(PI_Q16)) begin
            err_wrap = err_wrap + (Q_W+2)'(TWO_PI_Q16);
         end
      end
      // Clip to the 32-bit range
      if (err_wrap[Q_W+1:Q_W-1] == '0 || err_wrap[Q_W+1:Q_W-1] == '1) begin
         err_sat = err_wrap[Q_W-1:0];
      end else if (err_wrap[Q_W+1]) begin
         err_sat = {1'b1, {(Q_W-1){1'b0}}};
      end else begin
         err_sat = {1'b0, {(Q_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ctl_ff <= '0;
      end else begin
         p1_ctl_ff <= p0_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_err_ff  <= err_sat;
      p1_gain_ff <= rd_gain;
      p1_ffwd_ff <= p0_ffwd_ff;
   end

   // ---------------------------------------------------------------------------------
   // Stage 2: one product per command lane
   // ---------------------------------------------------------------------------------
   stage_ctl_type            p2_ctl_ff;
   logic signed [PROD_W-1:0] p2_prod_ff [COMMAND_OUTPUTS];
   q_vec_type                p2_ffwd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_ctl_ff <= '0;
      end else begin
         p2_ctl_ff <= p1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < COMMAND_OUTPUTS; r++) begin
         p2_prod_ff[r] <= $signed(p1_gain_ff[r]) * p1_err_ff;
      end
      p2_ffwd_ff <= p1_ffwd_ff;
   end

   // ---------------------------------------------------------------------------------
   // Accumulators: load feed-forward on a step, subtract scaled products with saturation on a component, hold otherwise
   // ---------------------------------------------------------------------------------
   logic signed [ACC_W-1:0] acc_ff [COMMAND_OUTPUTS];
   logic signed [ACC_W-1:0] acc_in [COMMAND_OUTPUTS];
   logic signed [ACC_W-1:0] prod_sh;
   logic signed [ACC_W:0]   acc_sub;
   stage_ctl_type           p3_ctl_ff;

   always_comb begin
      prod_sh = '0;
      acc_sub = '0;
      for (int r = 0; r < COMMAND_OUTPUTS; r++) begin
         acc_in[r] = acc_ff[r];
         // Arithmetic shift floors the Q32.32 product to Q32.16, the accumulator format
         prod_sh   = p2_prod_ff[r][PROD_W-1:FRAC_W];
         acc_sub   = {acc_ff[r][ACC_W-1], acc_ff[r]} - {prod_sh[ACC_W-1], prod_sh};
         if (p2_ctl_ff.step) begin
            acc_in[r] = {{(ACC_W-Q_W){p2_ffwd_ff[r][Q_W-1]}}, p2_ffwd_ff[r]};
         end else if (p2_ctl_ff.acc_en) begin
            if (acc_sub[ACC_W] != acc_sub[ACC_W-1]) begin
               acc_in[r] = acc_sub[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                          : {1'b0, {(ACC_W-1){1'b1}}};
            end else begin
               acc_in[r] = acc_sub[ACC_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < COMMAND_OUTPUTS; r++) begin
            acc_ff[r] <= '0;
         end
         p3_ctl_ff <= '0;
      end else begin
         for (int r = 0; r < COMMAND_OUTPUTS; r++) begin
            acc_ff[r] <= acc_in[r];
         end
         p3_ctl_ff <= p2_ctl_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 4: clip accumulators to 32 bits
   // ---------------------------------------------------------------------------------
   stage_ctl_type p4_ctl_ff;
   q_vec_type     cmd_sat;
   q_vec_type     p4_cmd_ff;

   always_comb begin
      for (int r = 0; r < COMMAND_OUTPUTS; r++) begin
         if (acc_ff[r][ACC_W-1:Q_W-1] == '0 || acc_ff[r][ACC_W-1:Q_W-1] == '1) begin
            cmd_sat[r] = acc_ff[r][Q_W-1:0];
         end else if (acc_ff[r][ACC_W-1]) begin
            cmd_sat[r] = {1'b1, {(Q_W-1){1'b0}}};
         end else begin
            cmd_sat[r] = {1'b0, {(Q_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_ctl_ff <= '0;
      end else begin
         p4_ctl_ff <= p3_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      p4_cmd_ff <= cmd_sat;
   end

   // ---------------------------------------------------------------------------------
   // Command shaping: thrust ceiling, disable, torque gating
   // ---------------------------------------------------------------------------------
   rsp_item_type          rsp_new;
   logic signed [Q_W-1:0] thrust_lim;

   always_comb begin
      thrust_lim = $signed(p4_cmd_ff[0]);
      if ($signed(p4_cmd_ff[0]) > $signed({1'b0, thrust_ceil_ff})) begin
         thrust_lim = $signed({1'b0, thrust_ceil_ff});
      end
      if (p4_ctl_ff.dis) begin
         thrust_lim = '0;
      end
      rsp_new.thrust   = thrust_lim;
      rsp_new.torque_x = (thrust_lim > 0) ? $signed(p4_cmd_ff[1]) : '0;
      rsp_new.torque_y = (thrust_lim > 0) ? $signed(p4_cmd_ff[2]) : '0;
      rsp_new.torque_z = (thrust_lim > 0) ? $signed(p4_cmd_ff[3]) : '0;
      rsp_new.fallback = p4_ctl_ff.fb;
   end

   // ---------------------------------------------------------------------------------
   // Response queue with credits for commands still in the pipeline
   // ---------------------------------------------------------------------------------
   rsp_item_type         rsp_q_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] rsp_wr_ptr_ff;
   logic [RSP_PTR_W-1:0] rsp_rd_ptr_ff;
   logic [RSP_CNT_W-1:0] rsp_cnt_ff;
   logic [RSP_CNT_W-1:0] credit_ff;
   logic                 rsp_push;
   logic                 rsp_pop;
   logic                 credit_take;

   assign rsp_push    = p4_ctl_ff.emit;
   assign rsp_pop     = rsp_tvalid && rsp_tready;
   assign credit_take = req_acc && in_action == ACT_COMPONENT && req_tlast;
   assign req_tready  = credit_ff < RSP_CNT_W'(RSP_DEPTH);
   assign rsp_tvalid  = rsp_cnt_ff != '0;
   assign rsp_tdata   = RSP_TDATA_W'(rsp_q_ff[rsp_rd_ptr_ff]);

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rsp_q_ff[rsp_wr_ptr_ff] <= rsp_new;
      end
   end

   // Advance pointers and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_wr_ptr_ff <= '0;
         rsp_rd_ptr_ff <= '0;
         rsp_cnt_ff    <= '0;
         credit_ff     <= '0;
      end else begin
         if (rsp_push) begin
            rsp_wr_ptr_ff <= rsp_wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (rsp_pop) begin
            rsp_rd_ptr_ff <= rsp_rd_ptr_ff + RSP_PTR_W'(1);
         end
         rsp_cnt_ff <= rsp_cnt_ff + RSP_CNT_W'(rsp_push) - RSP_CNT_W'(rsp_pop);
         credit_ff  <= credit_ff + RSP_CNT_W'(credit_take) - RSP_CNT_W'(rsp_pop);
      end
   end

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_cnt_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("response queue count exceeds depth");

   a_credit_cover: assert property (@(posedge clock) disable iff (reset)
      credit_ff >= rsp_cnt_ff)
      else $error("queued commands exceed reserved credits");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (rsp_cnt_ff < RSP_CNT_W'(RSP_DEPTH)) || rsp_pop)
      else $error("command pushed into a full response queue");

   a_emit_latency: assert property (@(posedge clock) disable iff (reset)
      credit_take |=> ##4 rsp_push)
      else $error("last component did not reach the response queue");

endmodule

`default_nettype wire
